FILE: src/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg: shared types and constants for the EC scalar multiply core
// Field widths, ALU op codes, register selects, microcode ROM and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none
package ecsm_pkg;

  localparam int MOD_BITS    = 50;
  localparam int SCALAR_BITS = 63;
  localparam int CFG_IDX_W   = 1;
  localparam int MUL_STEPS   = 2 * MOD_BITS;
  localparam int MCNT_W      = $clog2(MUL_STEPS + 1);
  localparam int UPC_W       = 5;

  typedef logic [MOD_BITS-1:0]    resid_t;
  typedef logic [SCALAR_BITS-1:0] scalar_t;
  typedef logic [UPC_W-1:0]       upc_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = CFG_IDX_W'(1);

  // Smallest modulus accepted
  localparam resid_t MIN_MODULUS = MOD_BITS'(3);

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_INV, OP_MOV
  } alu_op_t;

  // Working register selects; DX/DY are the destination point of a doubling
  typedef enum logic [3:0] {
    R_QX, R_QY, R_UX, R_UY, R_T, R_N, R_S, R_VX, R_A, R_ONE, R_DX, R_DY
  } reg_sel_t;

  typedef struct packed {
    alu_op_t  op;
    reg_sel_t sa;
    reg_sel_t sb;
    reg_sel_t dst;
    logic     last;
  } uop_t;

  // Microcode entry points
  localparam upc_t UPC_INIT = UPC_W'(0);
  localparam upc_t UPC_DBL  = UPC_W'(3);
  localparam upc_t UPC_ADD  = UPC_W'(17);

  typedef struct packed {
    logic    start;
    alu_op_t op;
    resid_t  p;
    resid_t  a;
    resid_t  b;
  } alu_req_t;

  typedef struct packed {
    logic   done;
    resid_t result;
  } alu_rsp_t;

  typedef struct packed {
    logic    start;
    resid_t  px;
    resid_t  py;
    scalar_t scalar;
    resid_t  p;
    resid_t  a;
  } job_t;

  typedef struct packed {
    logic   load;
    resid_t x;
    resid_t y;
    logic   inf;
  } result_t;

  typedef enum logic [1:0] {AL_IDLE, AL_MUL, AL_INV} alu_state_t;

  typedef enum logic [2:0] {
    CT_IDLE, CT_ISSUE, CT_WAIT, CT_BIT, CT_SHIFT, CT_DONE
  } ctrl_state_t;

  typedef enum logic {RET_BIT, RET_SHIFT} ret_t;

  function automatic uop_t mk_uop(input alu_op_t op, input reg_sel_t sa,
                                  input reg_sel_t sb, input reg_sel_t dst,
                                  input logic last);
    uop_t u;
    u.op   = op;
    u.sa   = sa;
    u.sb   = sb;
    u.dst  = dst;
    u.last = last;
    return u;
  endfunction

  // Microcode: operand reduction, point doubling, point addition
  function automatic uop_t uop_rom(input upc_t upc);
    uop_t u;
    unique case (upc)
      // reduce inputs: 1 * x mod p
      5'd0:  u = mk_uop(OP_MUL, R_ONE, R_QX,  R_QX,  1'b0);
      5'd1:  u = mk_uop(OP_MUL, R_ONE, R_QY,  R_QY,  1'b0);
      5'd2:  u = mk_uop(OP_MUL, R_ONE, R_A,   R_A,   1'b1);
      // doubling of Q
      5'd3:  u = mk_uop(OP_MUL, R_QX,  R_QX,  R_T,   1'b0);
      5'd4:  u = mk_uop(OP_ADD, R_T,   R_T,   R_N,   1'b0);
      5'd5:  u = mk_uop(OP_ADD, R_N,   R_T,   R_N,   1'b0);
      5'd6:  u = mk_uop(OP_ADD, R_N,   R_A,   R_N,   1'b0);
      5'd7:  u = mk_uop(OP_ADD, R_QY,  R_QY,  R_S,   1'b0);
      5'd8:  u = mk_uop(OP_INV, R_S,   R_ONE, R_S,   1'b0);
      5'd9:  u = mk_uop(OP_MUL, R_N,   R_S,   R_S,   1'b0);
      5'd10: u = mk_uop(OP_MUL, R_S,   R_S,   R_VX,  1'b0);
      5'd11: u = mk_uop(OP_SUB, R_VX,  R_QX,  R_VX,  1'b0);
      5'd12: u = mk_uop(OP_SUB, R_VX,  R_QX,  R_VX,  1'b0);
      5'd13: u = mk_uop(OP_SUB, R_QX,  R_VX,  R_T,   1'b0);
      5'd14: u = mk_uop(OP_MUL, R_T,   R_S,   R_T,   1'b0);
      5'd15: u = mk_uop(OP_SUB, R_T,   R_QY,  R_DY,  1'b0);
      5'd16: u = mk_uop(OP_MOV, R_VX,  R_ONE, R_DX,  1'b1);
      // addition U + Q
      5'd17: u = mk_uop(OP_SUB, R_UY,  R_QY,  R_S,   1'b0);
      5'd18: u = mk_uop(OP_SUB, R_UX,  R_QX,  R_T,   1'b0);
      5'd19: u = mk_uop(OP_INV, R_T,   R_ONE, R_T,   1'b0);
      5'd20: u = mk_uop(OP_MUL, R_S,   R_T,   R_S,   1'b0);
      5'd21: u = mk_uop(OP_MUL, R_S,   R_S,   R_VX,  1'b0);
      5'd22: u = mk_uop(OP_SUB, R_VX,  R_UX,  R_VX,  1'b0);
      5'd23: u = mk_uop(OP_SUB, R_VX,  R_QX,  R_VX,  1'b0);
      5'd24: u = mk_uop(OP_SUB, R_UX,  R_VX,  R_T,   1'b0);
      5'd25: u = mk_uop(OP_MUL, R_T,   R_S,   R_T,   1'b0);
      5'd26: u = mk_uop(OP_SUB, R_T,   R_UY,  R_UY,  1'b0);
      5'd27: u = mk_uop(OP_MOV, R_VX,  R_ONE, R_UX,  1'b1);
      default: u = mk_uop(OP_MOV, R_ONE, R_ONE, R_T, 1'b1);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: src/ecsm_if.sv
// ----------------------------------------------------------------------------
// ecsm_if: channel interfaces of the EC scalar multiply core
// Point request, result and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface ecsm_in_if import ecsm_pkg::*; ();
  logic    valid;
  logic    ready;
  resid_t  point_x;
  resid_t  point_y;
  scalar_t scalar;
  modport source (output valid, point_x, point_y, scalar, input ready);
  modport sink   (input valid, point_x, point_y, scalar, output ready);
endinterface

interface ecsm_out_if import ecsm_pkg::*; ();
  logic   valid;
  logic   ready;
  resid_t result_x;
  resid_t result_y;
  logic   at_infinity;
  modport source (output valid, result_x, result_y, at_infinity, input ready);
  modport sink   (input valid, result_x, result_y, at_infinity, output ready);
endinterface

interface ecsm_cfg_if import ecsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  resid_t               data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

FILE: src/ecsm_mod_alu.sv
// ----------------------------------------------------------------------------
// ecsm_mod_alu: serial modular arithmetic unit
// Add, subtract and move directly; multiply by a double and an add per bit of b;
// inverse by binary extended Euclid, one reduction step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ecsm_mod_alu import ecsm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  alu_state_t        state_r, state_nxt;
  resid_t            acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt;
  resid_t            u_r, u_nxt, v_r, v_nxt, x1_r, x1_nxt, x2_r, x2_nxt;
  resid_t            result_r, result_nxt;
  logic              done_r, done_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  resid_t            acc_step;

  function automatic resid_t addm(input resid_t x, input resid_t y, input resid_t p);
    logic [MOD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[MOD_BITS-1:0];
  endfunction

  function automatic resid_t subm(input resid_t x, input resid_t y, input resid_t p);
    logic [MOD_BITS:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + {1'b0, p} - {1'b0, y};
    return s[MOD_BITS-1:0];
  endfunction

  // Halve modulo an odd p
  function automatic resid_t halvem(input resid_t x, input resid_t p);
    logic [MOD_BITS:0] s;
    s = x[0] ? ({1'b0, x} + {1'b0, p}) : {1'b0, x};
    return s[MOD_BITS:1];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AL_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    acc_r    <= acc_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    u_r      <= u_nxt;
    v_r      <= v_nxt;
    x1_r     <= x1_nxt;
    x2_r     <= x2_nxt;
    cnt_r    <= cnt_nxt;
    result_r <= result_nxt;
  end

  // Sequence the operation
  always_comb begin
    state_nxt  = state_r;
    done_nxt   = 1'b0;
    acc_nxt    = acc_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    u_nxt      = u_r;
    v_nxt      = v_r;
    x1_nxt     = x1_r;
    x2_nxt     = x2_r;
    cnt_nxt    = cnt_r;
    result_nxt = result_r;
    acc_step   = acc_r;
    unique case (state_r)
      AL_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            OP_ADD: begin
              result_nxt = addm(req.a, req.b, req.p);
              done_nxt   = 1'b1;
            end
            OP_SUB: begin
              result_nxt = subm(req.a, req.b, req.p);
              done_nxt   = 1'b1;
            end
            OP_MUL: begin
              acc_nxt   = '0;
              a_nxt     = req.a;
              b_nxt     = req.b;
              cnt_nxt   = '0;
              state_nxt = AL_MUL;
            end
            OP_INV: begin
              u_nxt     = req.a;
              v_nxt     = req.p;
              x1_nxt    = MOD_BITS'(1);
              x2_nxt    = '0;
              state_nxt = AL_INV;
            end
            default: begin
              result_nxt = req.a;
              done_nxt   = 1'b1;
            end
          endcase
        end
      end
      AL_MUL: begin
        // even step doubles, odd step adds a on the current bit of b
        if (!cnt_r[0]) begin
          acc_step = addm(acc_r, acc_r, req.p);
        end else begin
          if (b_r[MOD_BITS-1]) acc_step = addm(acc_r, a_r, req.p);
          b_nxt = {b_r[MOD_BITS-2:0], 1'b0};
        end
        acc_nxt = acc_step;
        cnt_nxt = cnt_r + MCNT_W'(1);
        if (cnt_r == MCNT_W'(MUL_STEPS - 1)) begin
          result_nxt = acc_step;
          done_nxt   = 1'b1;
          state_nxt  = AL_IDLE;
        end
      end
      AL_INV: begin
        // keep x1*a = u and x2*a = v modulo p
        if (u_r == '0) begin
          result_nxt = (v_r == MOD_BITS'(1)) ? x2_r : '0;
          done_nxt   = 1'b1;
          state_nxt  = AL_IDLE;
        end else if (!u_r[0]) begin
          u_nxt  = u_r >> 1;
          x1_nxt = halvem(x1_r, req.p);
        end else if (!v_r[0]) begin
          v_nxt  = v_r >> 1;
          x2_nxt = halvem(x2_r, req.p);
        end else if (u_r >= v_r) begin
          u_nxt  = u_r - v_r;
          x1_nxt = subm(x1_r, x2_r, req.p);
        end else begin
          v_nxt  = v_r - u_r;
          x2_nxt = subm(x2_r, x1_r, req.p);
        end
      end
      default: state_nxt = AL_IDLE;
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.result = result_r;

endmodule
`default_nettype wire

FILE: src/ecsm_ctrl.sv
// ----------------------------------------------------------------------------
// ecsm_ctrl: double-and-add sequencer
// Holds the working point registers, walks the scalar from its low bit and
// runs microcode routines on the modular ALU.
// ----------------------------------------------------------------------------
`default_nettype none
module ecsm_ctrl import ecsm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire job_t     job,
  input  wire logic     res_free,
  input  wire alu_rsp_t alu_rsp,
  output logic          idle,
  output alu_req_t      alu_req,
  output result_t       res
);

  ctrl_state_t state_r, state_nxt;
  upc_t        upc_r, upc_nxt;
  ret_t        ret_r, ret_nxt;
  logic        dst_u_r, dst_u_nxt;
  logic        uinf_r, uinf_nxt;
  resid_t      qx_r, qx_nxt, qy_r, qy_nxt, ux_r, ux_nxt, uy_r, uy_nxt;
  resid_t      t_r, t_nxt, n_r, n_nxt, s_r, s_nxt, vx_r, vx_nxt;
  resid_t      a_r, a_nxt, p_r, p_nxt;
  scalar_t     m_r, m_nxt, m_shr;
  uop_t        uop;

  function automatic resid_t rd(input reg_sel_t sel, input resid_t qx, input resid_t qy,
                                input resid_t ux, input resid_t uy, input resid_t t,
                                input resid_t n, input resid_t s, input resid_t vx,
                                input resid_t a);
    resid_t r;
    unique case (sel)
      R_QX:    r = qx;
      R_QY:    r = qy;
      R_UX:    r = ux;
      R_UY:    r = uy;
      R_T:     r = t;
      R_N:     r = n;
      R_S:     r = s;
      R_VX:    r = vx;
      R_A:     r = a;
      R_ONE:   r = MOD_BITS'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    upc_r   <= upc_nxt;
    ret_r   <= ret_nxt;
    dst_u_r <= dst_u_nxt;
    uinf_r  <= uinf_nxt;
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    ux_r    <= ux_nxt;
    uy_r    <= uy_nxt;
    t_r     <= t_nxt;
    n_r     <= n_nxt;
    s_r     <= s_nxt;
    vx_r    <= vx_nxt;
    a_r     <= a_nxt;
    p_r     <= p_nxt;
    m_r     <= m_nxt;
  end

  assign uop   = uop_rom(upc_r);
  assign m_shr = m_r >> 1;

  // Issue the current micro-op
  always_comb begin
    alu_req.start = (state_r == CT_ISSUE);
    alu_req.op    = uop.op;
    alu_req.p     = p_r;
    alu_req.a     = rd(uop.sa, qx_r, qy_r, ux_r, uy_r, t_r, n_r, s_r, vx_r, a_r);
    alu_req.b     = rd(uop.sb, qx_r, qy_r, ux_r, uy_r, t_r, n_r, s_r, vx_r, a_r);
  end

  // Next state and working registers
  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    ret_nxt   = ret_r;
    dst_u_nxt = dst_u_r;
    uinf_nxt  = uinf_r;
    qx_nxt    = qx_r;
    qy_nxt    = qy_r;
    ux_nxt    = ux_r;
    uy_nxt    = uy_r;
    t_nxt     = t_r;
    n_nxt     = n_r;
    s_nxt     = s_r;
    vx_nxt    = vx_r;
    a_nxt     = a_r;
    p_nxt     = p_r;
    m_nxt     = m_r;
    idle      = 1'b0;
    res.load  = 1'b0;
    res.x     = uinf_r ? '0 : ux_r;
    res.y     = uinf_r ? '0 : uy_r;
    res.inf   = uinf_r;
    unique case (state_r)
      CT_IDLE: begin
        idle = 1'b1;
        if (job.start) begin
          qx_nxt    = job.px;
          qy_nxt    = job.py;
          a_nxt     = job.a;
          p_nxt     = job.p;
          m_nxt     = job.scalar;
          ux_nxt    = '0;
          uy_nxt    = '0;
          uinf_nxt  = 1'b1;
          dst_u_nxt = 1'b0;
          upc_nxt   = UPC_INIT;
          ret_nxt   = RET_BIT;
          state_nxt = CT_ISSUE;
        end
      end
      CT_ISSUE: state_nxt = CT_WAIT;
      CT_WAIT: begin
        if (alu_rsp.done) begin
          unique case (uop.dst)
            R_QX: qx_nxt = alu_rsp.result;
            R_QY: qy_nxt = alu_rsp.result;
            R_UX: ux_nxt = alu_rsp.result;
            R_UY: uy_nxt = alu_rsp.result;
            R_T:  t_nxt  = alu_rsp.result;
            R_N:  n_nxt  = alu_rsp.result;
            R_S:  s_nxt  = alu_rsp.result;
            R_VX: vx_nxt = alu_rsp.result;
            R_A:  a_nxt  = alu_rsp.result;
            R_DX: begin
              if (dst_u_r) ux_nxt = alu_rsp.result;
              else         qx_nxt = alu_rsp.result;
            end
            R_DY: begin
              if (dst_u_r) uy_nxt = alu_rsp.result;
              else         qy_nxt = alu_rsp.result;
            end
            default: t_nxt = t_r;
          endcase
          if (uop.last) begin
            state_nxt = (ret_r == RET_BIT) ? CT_BIT : CT_SHIFT;
          end else begin
            upc_nxt   = upc_r + UPC_W'(1);
            state_nxt = CT_ISSUE;
          end
        end
      end
      CT_BIT: begin
        // add Q into U on a set scalar bit; finish once no bits are left
        if (m_r == '0) begin
          state_nxt = CT_DONE;
        end else if (!m_r[0]) begin
          state_nxt = CT_SHIFT;
        end else if (uinf_r) begin
          ux_nxt    = qx_r;
          uy_nxt    = qy_r;
          uinf_nxt  = 1'b0;
          state_nxt = CT_SHIFT;
        end else if (ux_r == qx_r) begin
          if (uy_r == qy_r && uy_r != '0) begin
            dst_u_nxt = 1'b1;
            upc_nxt   = UPC_DBL;
            ret_nxt   = RET_SHIFT;
            state_nxt = CT_ISSUE;
          end else begin
            uinf_nxt  = 1'b1;
            state_nxt = CT_SHIFT;
          end
        end else begin
          upc_nxt   = UPC_ADD;
          ret_nxt   = RET_SHIFT;
          state_nxt = CT_ISSUE;
        end
      end
      CT_SHIFT: begin
        // drop the used bit, then double Q unless finished
        m_nxt = m_shr;
        if (m_shr == '0 || qy_r == '0) begin
          state_nxt = CT_DONE;
        end else begin
          dst_u_nxt = 1'b0;
          upc_nxt   = UPC_DBL;
          ret_nxt   = RET_BIT;
          state_nxt = CT_ISSUE;
        end
      end
      CT_DONE: begin
        if (res_free) begin
          res.load  = 1'b1;
          state_nxt = CT_IDLE;
        end
      end
      default: state_nxt = CT_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/ec_point_scalar_multiply_core.sv
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply_core: affine EC scalar multiplication over GF(p)
// Right-to-left double-and-add on a serial modular ALU, one request at a time.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                               | handshake
//  in_ch    | in  | point_x, point_y, scalar              | valid/ready
//  out_ch   | out | result_x, result_y, at_infinity       | valid/ready
//  cfg_ch   | in  | addr (0 modulus, 1 curve_a), data     | valid/ready
//
//  A request first reduces its operands, then per scalar bit runs up to
//  two point operations, each a chain of modular multiplies, adds,
//  subtracts and one inverse; all of them run on the shared serial ALU,
//  one operation at a time.
//  Reset (synchronous, rst_n low) sets modulus to 3 and curve_a to 0.
//  A finished result waits in the output register; a stalled out_ch holds
//  the sequencer at its end, and the next request is taken once it is free.
// ----------------------------------------------------------------------------
`default_nettype none
module ec_point_scalar_multiply_core import ecsm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ecsm_in_if.sink   in_ch,
  ecsm_out_if.source out_ch,
  ecsm_cfg_if.sink  cfg_ch
);

  resid_t   modulus_r, modulus_nxt, curve_a_r, curve_a_nxt;
  logic     out_valid_r, out_valid_nxt;
  resid_t   out_x_r, out_y_r;
  logic     out_inf_r;
  logic     idle;
  job_t     job;
  result_t  res;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Configuration writes
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    modulus_nxt = modulus_r;
    curve_a_nxt = curve_a_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_MODULUS: modulus_nxt = cfg_ch.data;
        CFG_CURVE_A: curve_a_nxt = cfg_ch.data;
        default:     modulus_nxt = modulus_r;
      endcase
    end
  end

  // Start a request
  assign in_ch.ready = idle;
  assign job.start   = in_ch.valid & idle;
  assign job.px      = in_ch.point_x;
  assign job.py      = in_ch.point_y;
  assign job.scalar  = in_ch.scalar;
  assign job.p       = (modulus_r < MIN_MODULUS) ? MIN_MODULUS : modulus_r;
  assign job.a       = curve_a_r;

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (res.load)     out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MIN_MODULUS;
      curve_a_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      modulus_r   <= modulus_nxt;
      curve_a_r   <= curve_a_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (res.load) begin
      out_x_r   <= res.x;
      out_y_r   <= res.y;
      out_inf_r <= res.inf;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_x    = out_x_r;
  assign out_ch.result_y    = out_y_r;
  assign out_ch.at_infinity = out_inf_r;

  ecsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job),
    .res_free (!out_valid_r || out_ch.ready),
    .alu_rsp  (alu_rsp),
    .idle     (idle),
    .alu_req  (alu_req),
    .res      (res)
  );

  ecsm_mod_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

endmodule
`default_nettype wire

FILE: sim/tb_ec_point_scalar_multiply_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ec_point_scalar_multiply_core: self-checking bench for the EC multiplier
// Sweeps several field settings, drives directed and random point requests,
// predicts each product with an integer double-and-add and checks every field.
// ----------------------------------------------------------------------------
module tb_ec_point_scalar_multiply_core;
  import ecsm_pkg::*;

  typedef bit [63:0] u64_t;

  typedef struct {
    u64_t x;
    u64_t y;
    bit   inf;
  } ecpt_t;

  typedef struct {
    resid_t  px;
    resid_t  py;
    scalar_t k;
  } point_req_t;

  localparam u64_t RMASK = (64'd1 << MOD_BITS) - 1;
  localparam u64_t BIG_PRIME = 64'd1125899906842597;

  logic clk;
  logic rst_n;
  int   cyc;
  int   n_err;

  ecsm_in_if  in_ch ();
  ecsm_out_if out_ch ();
  ecsm_cfg_if cfg_ch ();

  ec_point_scalar_multiply_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // bench copy of the field registers
  u64_t       fld_mod;
  u64_t       fld_a;
  point_req_t pending_reqs[$];
  ecpt_t      expected_products[$];

  // ---------------------------------------------------------------- field ops
  function automatic u64_t f_add(u64_t a, u64_t b, u64_t p);
    if (a >= p - b) return a - (p - b);
    return a + b;
  endfunction

  function automatic u64_t f_sub(u64_t a, u64_t b, u64_t p);
    if (a >= b) return a - b;
    return a + (p - b);
  endfunction

  function automatic u64_t f_mul(u64_t a, u64_t b, u64_t p);
    u64_t r;
    r = 0;
    for (int k = 63; k >= 0; k--) begin
      r = f_add(r, r, p);
      if (b[k]) r = f_add(r, a, p);
    end
    return r;
  endfunction

  // extended Euclid; a non-unit gives zero
  function automatic u64_t f_inv(u64_t a, u64_t p);
    u64_t r0, r1, t0, t1, q, tmp;
    r0 = p; r1 = a; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q   = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = f_sub(t0, f_mul(q % p, t1, p), p); t0 = t1; t1 = tmp;
    end
    return (r0 == 1) ? t0 : 64'd0;
  endfunction

  function automatic ecpt_t pt_from_slope(ecpt_t a, ecpt_t b, u64_t s, u64_t p);
    ecpt_t v;
    v.x   = f_sub(f_sub(f_mul(s, s, p), a.x, p), b.x, p);
    v.y   = f_sub(f_mul(f_sub(a.x, v.x, p), s, p), a.y, p);
    v.inf = 0;
    return v;
  endfunction

  function automatic ecpt_t pt_double(ecpt_t a, u64_t ca, u64_t p);
    ecpt_t z;
    u64_t  t, n, s;
    z = '{0, 0, 1};
    if (a.inf || a.y == 0) return z;
    t = f_mul(a.x, a.x, p);
    n = f_add(f_add(f_add(t, t, p), t, p), ca, p);
    s = f_mul(n, f_inv(f_add(a.y, a.y, p), p), p);
    return pt_from_slope(a, a, s, p);
  endfunction

  function automatic ecpt_t pt_add(ecpt_t a, ecpt_t b, u64_t ca, u64_t p);
    ecpt_t z;
    u64_t  s;
    z = '{0, 0, 1};
    if (a.inf) return b;
    if (b.inf) return a;
    if (a.x == b.x) begin
      if (a.y == b.y) return pt_double(a, ca, p);
      return z;
    end
    s = f_mul(f_sub(a.y, b.y, p), f_inv(f_sub(a.x, b.x, p), p), p);
    return pt_from_slope(a, b, s, p);
  endfunction

  // right-to-left double-and-add under the current field setting
  function automatic ecpt_t scalar_product(point_req_t r);
    u64_t  p, ca, m;
    ecpt_t q, u;
    p   = (fld_mod < 3) ? 64'd3 : fld_mod;
    ca  = fld_a % p;
    m   = u64_t'(r.k);
    q.x = u64_t'(r.px) % p;
    q.y = u64_t'(r.py) % p;
    q.inf = 0;
    u = '{0, 0, 1};
    while (m != 0) begin
      if (m[0]) u = pt_add(u, q, ca, p);
      m = m >> 1;
      if (m == 0) break;
      q = pt_double(q, ca, p);
      if (q.inf) break;
    end
    if (u.inf) u = '{0, 0, 1};
    return u;
  endfunction

  // random stalls, with a long quiet window in every period
  function automatic bit stall_now();
    if ((cyc % 40000) < 12000) return 0;
    return $urandom_range(99) < 24;
  endfunction

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // ---------------------------------------------------------------- request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_products.push_back(scalar_product(pending_reqs[0]));
        void'(pending_reqs.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the request until taken
      end else if (pending_reqs.size() > 0 && !stall_now()) begin
        in_ch.valid   <= 1'b1;
        in_ch.point_x <= pending_reqs[0].px;
        in_ch.point_y <= pending_reqs[0].py;
        in_ch.scalar  <= pending_reqs[0].k;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_products.size() == 0) begin
          $error("unexpected result x=%0h y=%0h inf=%0b",
                 out_ch.result_x, out_ch.result_y, out_ch.at_infinity);
          n_err++;
        end else begin
          if (out_ch.result_x !== resid_t'(expected_products[0].x)) begin
            $error("result_x expected %0h got %0h", expected_products[0].x, out_ch.result_x);
            n_err++;
          end
          if (out_ch.result_y !== resid_t'(expected_products[0].y)) begin
            $error("result_y expected %0h got %0h", expected_products[0].y, out_ch.result_y);
            n_err++;
          end
          if (out_ch.at_infinity !== expected_products[0].inf) begin
            $error("at_infinity expected %0b got %0b",
                   expected_products[0].inf, out_ch.at_infinity);
            n_err++;
          end
          void'(expected_products.pop_front());
        end
      end
      out_ch.ready <= !stall_now();
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input u64_t val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= resid_t'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_MODULUS) fld_mod = val & RMASK;
    else fld_a = val & RMASK;
  endtask

  task automatic queue_req(input u64_t x, input u64_t y, input u64_t k);
    point_req_t r;
    r.px = resid_t'(x);
    r.py = resid_t'(y);
    r.k  = scalar_t'(k);
    pending_reqs.push_back(r);
  endtask

  // drain: nothing pending, nothing in flight, then settle
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() > 0 || in_ch.valid || expected_products.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random items; wide marks a few with full-width scalars
  task automatic queue_random(input int n, input int wide);
    u64_t x, y, k, p;
    p = (fld_mod < 3) ? 64'd3 : fld_mod;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      x = {$urandom, $urandom} & RMASK;
      y = {$urandom, $urandom} & RMASK;
      if ($urandom_range(3) != 0) begin
        x = x % p;
        y = y % p;
      end
      if (i < wide) k = {$urandom, $urandom} >> 1;
      else case ($urandom_range(9))
        0: k = $urandom_range(1);
        1: k = $urandom_range(2, 7);
        default: k = $urandom_range(8, 4095);
      endcase
      queue_req(x, y, k);
    end
  endtask

  localparam u64_t KMAX = (64'd1 << SCALAR_BITS) - 1;

  initial begin
    u64_t phase_mod[7] = '{7, 97, 15, 1, BIG_PRIME, RMASK, 1000003};
    u64_t phase_a[7]   = '{3, 2, 4, RMASK, RMASK, 0, 5};
    int   phase_wide[7] = '{0, 0, 0, 0, 3, 3, 1};
    cyc   = 0;
    n_err = 0;
    fld_mod = 3;
    fld_a   = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.point_x = '0; in_ch.point_y = '0; in_ch.scalar = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.addr = CFG_MODULUS; cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset field: zero scalar, identity, y = 0 doubling, unreduced inputs
    @(negedge clk);
    queue_req(1, 1, 0);
    queue_req(2, 1, 1);
    queue_req(1, 0, 2);
    queue_req(RMASK, RMASK, 5);
    queue_req(2, 2, 3);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_MODULUS, phase_mod[ph]);
      write_reg(CFG_CURVE_A, phase_a[ph]);
      if (ph == 4) begin
        // largest prime field: field extremes and scalar extremes
        @(negedge clk);
        queue_req(0, 0, 1);
        queue_req(BIG_PRIME - 1, BIG_PRIME - 1, 2);
        queue_req(RMASK, 0, 1);
        queue_req(5, 7, KMAX);
        queue_req(123456789, 987654321, 0);
        queue_req(3, BIG_PRIME - 3, 64'h2AAA_AAAA_AAAA_AAAA);
      end
      if (ph == 0) begin
        // y = 0 point doubles to infinity; then scalars of one and of three
        @(negedge clk);
        queue_req(3, 0, 2);
        queue_req(3, 4, 1);
        queue_req(1, 6, 3);
      end
      queue_random(13, phase_wide[ph]);
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (n_err == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #(80_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
